### src/scpu_pkg.sv
package scpu_pkg;

  // actions carried by an input item
  localparam logic [2:0] ACT_LOAD_PROG = 3'd0;
  localparam logic [2:0] ACT_LOAD_DATA = 3'd1;
  localparam logic [2:0] ACT_RESET     = 3'd2;
  localparam logic [2:0] ACT_STEP      = 3'd3;
  localparam logic [2:0] ACT_READ_DATA = 3'd4;
  localparam logic [2:0] ACT_READ_REG  = 3'd5;

  // halt causes
  localparam logic [1:0] HC_RUN   = 2'd0;
  localparam logic [1:0] HC_OP    = 2'd1;
  localparam logic [1:0] HC_LIMIT = 2'd2;
  localparam logic [1:0] HC_PC    = 2'd3;

  // opcode ranges
  localparam logic [7:0] OP_HALT    = 8'h00;
  localparam logic [7:0] OP_REG_MAX = 8'h07;
  localparam logic [7:0] OP_ALU_MAX = 8'h0F;
  localparam logic [7:0] OP_BR_LO   = 8'h10;
  localparam logic [7:0] OP_BR_HI   = 8'h1E;

  // low three opcode bits select the operation
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_SUB   = 3'd2;
  localparam logic [2:0] FN_MUL   = 3'd3;
  localparam logic [2:0] FN_DIV   = 3'd4;
  localparam logic [2:0] FN_LOAD  = 3'd5;
  localparam logic [2:0] FN_STORE = 3'd6;
  localparam logic [2:0] FN_MOVE  = 3'd7;

  localparam logic [15:0] LIMIT_RESET = 16'd2000;

  typedef enum logic [3:0] {
    S_IDLE, S_RDWAIT, S_FETCH, S_CHECK, S_RA, S_RB, S_RD,
    S_EXEC, S_DIV, S_LOAD, S_WB, S_STORE, S_DONE
  } state_t;

  // condition codes: z n c v
  function automatic logic cond_holds(input logic [3:0] c, input logic z,
                                      input logic n, input logic cy,
                                      input logic v);
    logic r;
    case (c)
      4'h0: r = z;
      4'h1: r = !z;
      4'h2: r = cy;
      4'h3: r = !cy;
      4'h4: r = n;
      4'h5: r = !n;
      4'h6: r = v;
      4'h7: r = !v;
      4'h8: r = cy && !z;
      4'h9: r = !cy || z;
      4'hA: r = (n == v);
      4'hB: r = (n != v);
      4'hC: r = !z && (n == v);
      4'hD: r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

### src/small_cpu_instruction_step.sv
// loads, core reset and a step while halted go straight to the result state;
// reads pass a read wait state; a divide step waits on the bit-serial divider
// throughput: one item at a time; the next item is taken the cycle after the
// result enters the output register
// reset: synchronous, clears core state, register valid bits and the limit to 2000;
// program and data memories are not cleared
module small_cpu_instruction_step import scpu_pkg::*; #(
  parameter int REG_COUNT  = 256,
  parameter int PROG_BYTES = 256,
  parameter int DATA_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic [11:0]        address,
  input  logic [7:0]         byte_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] program_counter,
  output logic               halted,
  output logic [1:0]         halt_cause,
  output logic [7:0]         last_opcode,
  output logic               flag_zero,
  output logic               flag_negative,
  output logic               flag_carry,
  output logic               flag_overflow,
  output logic signed [31:0] read_value,
  output logic [16:0]        steps_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  localparam int PA_W = $clog2(PROG_BYTES);
  localparam int DA_W = $clog2(DATA_BYTES);
  localparam int RA_W = $clog2(REG_COUNT);
  localparam logic [20:0] RECIP = 21'((1 << 24) / REG_COUNT + 1);

  // register index modulo the register count, by reciprocal and one correction
  function automatic logic [RA_W-1:0] reg_mod(input logic [11:0] v);
    logic [32:0] p;
    logic [16:0] qn;
    logic [16:0] r;
    p  = {21'd0, v} * {12'd0, RECIP};
    qn = 17'(p[32:24]) * 17'(REG_COUNT);
    r  = {5'd0, v} - qn;
    if (r[16]) r = r + 17'(REG_COUNT);
    return r[RA_W-1:0];
  endfunction

  function automatic logic addr_ok(input logic [31:0] x);
    return !x[31] && (x < 32'(DATA_BYTES - 3));
  endfunction

  state_t state, state_next;

  // core state
  logic [11:0] pc;
  logic        fz, fn, fc, fv;
  logic [16:0] steps;
  logic        halted_q;
  logic [1:0]  cause;
  logic [7:0]  last_op;
  logic [15:0] limit;

  // per item work registers
  logic [2:0]  act;
  logic [11:0] adr;
  logic        rd_oob;
  logic [31:0] rd;
  logic [2:0]  cnt;
  logic [11:0] here;
  logic        pcb;
  logic [31:0] ins;
  logic [31:0] a, b, ad, wb;

  logic [7:0] op, dst, s1, s2;
  assign op  = ins[31:24];
  assign dst = ins[23:16];
  assign s1  = ins[15:8];
  assign s2  = ins[7:0];

  // memories
  logic [7:0]  pmem [PROG_BYTES];
  logic [7:0]  dmem [DATA_BYTES];
  logic [31:0] rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;
  logic [7:0]  pm_q, dm_q;
  logic [31:0] rf_q;
  logic        rf_vq;
  logic [31:0] rval;

  logic            pm_we;
  logic [PA_W-1:0] pm_addr;
  logic            dm_we;
  logic [DA_W-1:0] dm_addr;
  logic [7:0]      dm_wdata;
  logic            rf_we;
  logic [RA_W-1:0] rf_waddr, rf_raddr;
  logic [31:0]     rf_wdata;
  logic            dv_start, dv_done;
  logic [31:0]     dv_q;

  logic        accept, out_free;
  logic        pc_bad_now;
  logic [16:0] steps_inc;
  logic [32:0] sum;
  logic [31:0] dif;
  logic [31:0] alu_r;
  logic [31:0] addr_x;
  logic [1:0]  bsel;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid || !out_stall;
  assign rval       = rf_vq ? rf_q : 32'd0;
  assign pc_bad_now = pc[11] || (pc >= 12'(PROG_BYTES - 4));
  assign steps_inc  = steps + 17'd1;
  assign sum        = {1'b0, a} + {1'b0, b};
  assign dif        = a - b;
  assign addr_x     = 32'(address);
  assign bsel       = 2'd3 - cnt[1:0];

  // add, sub and move result
  always_comb begin
    case (op[2:0])
      FN_ADD:  alu_r = sum[31:0];
      FN_SUB:  alu_r = dif;
      default: alu_r = b;
    endcase
  end

  scpu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (a),
    .divisor  (b),
    .done     (dv_done),
    .quotient (dv_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (action == ACT_STEP && !halted_q) begin
            state_next = pc_bad_now ? S_CHECK : S_FETCH;
          end else if (action == ACT_READ_DATA || action == ACT_READ_REG) begin
            state_next = S_RDWAIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RDWAIT: state_next = S_DONE;
      S_FETCH:  if (cnt == 3'd4) state_next = S_CHECK;
      S_CHECK: begin
        if (steps_inc > {1'b0, limit} || op == OP_HALT || op > OP_ALU_MAX) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RA;
        end
      end
      S_RA: state_next = S_RB;
      S_RB: state_next = S_RD;
      S_RD: state_next = S_EXEC;
      S_EXEC: begin
        case (op[2:0])
          FN_MUL:   state_next = S_WB;
          FN_DIV:   state_next = (b != 32'd0) ? S_DIV : S_DONE;
          FN_LOAD:  state_next = addr_ok(b) ? S_LOAD : S_DONE;
          FN_STORE: state_next = addr_ok(ad) ? S_STORE : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_DIV:   if (dv_done) state_next = S_DONE;
      S_LOAD:  if (cnt == 3'd4) state_next = S_WB;
      S_WB:    state_next = S_DONE;
      S_STORE: if (cnt == 3'd3) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    pm_we    = 1'b0;
    pm_addr  = here[PA_W-1:0] + PA_W'(cnt[1:0]);
    dm_we    = 1'b0;
    dm_addr  = b[DA_W-1:0] + DA_W'(cnt[1:0]);
    dm_wdata = b[{bsel, 3'b000} +: 8];
    rf_we    = 1'b0;
    rf_waddr = reg_mod({4'd0, dst});
    rf_wdata = alu_r;
    rf_raddr = reg_mod({4'd0, s1});
    dv_start = 1'b0;
    case (state)
      S_IDLE: begin
        pm_addr  = address[PA_W-1:0];
        pm_we    = accept && action == ACT_LOAD_PROG && ({1'b0, address} < 13'(PROG_BYTES));
        dm_addr  = addr_x[DA_W-1:0];
        dm_wdata = byte_value;
        dm_we    = accept && action == ACT_LOAD_DATA && ({5'd0, address} < 17'(DATA_BYTES));
        rf_raddr = reg_mod(address);
      end
      S_RA: rf_raddr = reg_mod({4'd0, s2});
      S_RB: rf_raddr = reg_mod({4'd0, dst});
      S_EXEC: begin
        rf_we    = (op[2:0] == FN_ADD) || (op[2:0] == FN_SUB) || (op[2:0] == FN_MOVE);
        dv_start = (op[2:0] == FN_DIV) && (b != 32'd0);
      end
      S_DIV: begin
        rf_we    = dv_done;
        rf_wdata = dv_q;
      end
      S_WB: begin
        rf_we    = 1'b1;
        rf_wdata = wb;
      end
      S_STORE: begin
        dm_we   = 1'b1;
        dm_addr = ad[DA_W-1:0] + DA_W'(cnt[1:0]);
      end
      default: ;
    endcase
  end

  // program memory
  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_addr] <= byte_value;
    pm_q <= pmem[pm_addr];
  end

  // data memory
  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_addr] <= dm_wdata;
    dm_q <= dmem[dm_addr];
  end

  // register file
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_q  <= rf_mem[rf_raddr];
    rf_vq <= rf_valid[rf_raddr];
  end

  // register valid bits, cleared by reset and core reset
  always_ff @(posedge clk) begin
    if (rst || (accept && action == ACT_RESET)) begin
      rf_valid <= '0;
    end else if (rf_we) begin
      rf_valid[rf_waddr] <= 1'b1;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // sequencer and core state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= '0;
      fz       <= 1'b0;
      fn       <= 1'b0;
      fc       <= 1'b0;
      fv       <= 1'b0;
      steps    <= '0;
      halted_q <= 1'b0;
      cause    <= HC_RUN;
      last_op  <= '0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            act    <= action;
            adr    <= address;
            rd     <= '0;
            rd_oob <= !({5'd0, address} < 17'(DATA_BYTES));
            cnt    <= '0;
            here   <= pc;
            pcb    <= pc_bad_now;
            ins    <= '0;
            if (action == ACT_RESET) begin
              pc       <= '0;
              fz       <= 1'b0;
              fn       <= 1'b0;
              fc       <= 1'b0;
              fv       <= 1'b0;
              steps    <= '0;
              halted_q <= 1'b0;
              cause    <= HC_RUN;
              last_op  <= '0;
            end
          end
        end
        S_RDWAIT: begin
          if (act == ACT_READ_DATA) begin
            rd <= rd_oob ? 32'd0 : {24'd0, dm_q};
          end else begin
            rd <= rval;
          end
        end
        // four instruction bytes, one per cycle
        S_FETCH: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) ins <= {ins[23:0], pm_q};
        end
        // count, limit and halt checks, branches
        S_CHECK: begin
          last_op <= op;
          steps   <= steps_inc;
          if (!pcb) pc <= here + 12'd4;
          if (steps_inc > {1'b0, limit}) begin
            halted_q <= 1'b1;
            cause    <= HC_LIMIT;
          end else if (op == OP_HALT) begin
            halted_q <= 1'b1;
            cause    <= pcb ? HC_PC : HC_OP;
          end else if (op >= OP_BR_LO && op <= OP_BR_HI) begin
            if (cond_holds(op[3:0], fz, fn, fc, fv)) begin
              pc <= here + {{2{s2[7]}}, s2, 2'b00};
            end
          end
        end
        S_RA: a <= rval;
        S_RB: b <= (op <= OP_REG_MAX) ? rval : {24'd0, s2};
        S_RD: ad <= rval;
        S_EXEC: begin
          cnt <= '0;
          if (op[2:0] == FN_ADD) begin
            fz <= (sum[31:0] == 32'd0);
            fn <= sum[31];
            fc <= sum[32];
            fv <= (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
          end else if (op[2:0] == FN_SUB) begin
            fz <= (dif == 32'd0);
            fn <= dif[31];
            fc <= (a >= b);
            fv <= (a[31] ^ b[31]) & (a[31] ^ dif[31]);
          end
          if (op[2:0] == FN_MUL) wb <= 32'(a * b);
        end
        // big-endian word gather
        S_LOAD: begin
          cnt <= cnt + 3'd1;
          if (cnt != 3'd0) wb <= {wb[23:0], dm_q};
        end
        S_STORE: cnt <= cnt + 3'd1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      program_counter <= pc;
      halted          <= halted_q;
      halt_cause      <= cause;
      last_opcode     <= last_op;
      flag_zero       <= fz;
      flag_negative   <= fn;
      flag_carry      <= fc;
      flag_overflow   <= fv;
      read_value      <= rd;
      steps_done      <= steps;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("sequencer idle after an accepted item");

  a_halt_has_cause: assert property (@(posedge clk) disable iff (rst)
    halted_q |-> cause != HC_RUN)
    else $error("halted without a cause");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_adr_used: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDWAIT && act == ACT_READ_DATA) |-> rd_oob == !({5'd0, adr} < 17'(DATA_BYTES)))
    else $error("read range flag does not match the latched address");

endmodule

### src/scpu_div.sv
module scpu_div import scpu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] rem_sh;
  logic [32:0] diff;

  // one restoring step per cycle
  assign rem_sh   = {rem[31:0], quo[31]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs  <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### tb/small_cpu_instruction_step_tb.sv
module small_cpu_instruction_step_tb;
  import scpu_pkg::*;

  localparam int PROG_SIZE = 256;
  localparam int DATA_SIZE = 4096;
  localparam int RUN_LIMIT = 1000000;
  localparam int SETTLE = 60;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 115;

  // actions the block does not use
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  // opcodes used by the directed program and the random instructions
  localparam logic [7:0] OP_ADD_REG  = {5'd0, FN_ADD};
  localparam logic [7:0] OP_MUL_REG  = {5'd0, FN_MUL};
  localparam logic [7:0] OP_DIV_REG  = {5'd0, FN_DIV};
  localparam logic [7:0] OP_STORE_RG = {5'd0, FN_STORE};
  localparam logic [7:0] OP_NOP_IMM  = 8'h08;
  localparam logic [7:0] OP_SUB_IMM  = {5'd1, FN_SUB};
  localparam logic [7:0] OP_MUL_IMM  = {5'd1, FN_MUL};
  localparam logic [7:0] OP_LOAD_IMM = {5'd1, FN_LOAD};
  localparam logic [7:0] OP_MOVE_IMM = {5'd1, FN_MOVE};

  typedef struct packed {
    logic [11:0] pc;
    logic        halted;
    logic [1:0]  cause;
    logic [7:0]  op;
    logic        z, n, c, v;
    logic [31:0] rv;
    logic [16:0] steps;
  } cpu_status_t;

  typedef struct {
    logic [2:0]  act;
    logic [11:0] addr;
    logic [7:0]  val;
    bit          typed;
    logic [31:0] rv;
    logic        halt;
    logic [1:0]  cause;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [11:0] address = '0;
  logic [7:0] byte_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [11:0] program_counter;
  logic halted;
  logic [1:0] halt_cause;
  logic [7:0] last_opcode;
  logic flag_zero, flag_negative, flag_carry, flag_overflow;
  logic signed [31:0] read_value;
  logic [16:0] steps_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  small_cpu_instruction_step uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .address(address), .byte_value(byte_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .program_counter(program_counter), .halted(halted), .halt_cause(halt_cause),
    .last_opcode(last_opcode), .flag_zero(flag_zero), .flag_negative(flag_negative),
    .flag_carry(flag_carry), .flag_overflow(flag_overflow),
    .read_value(read_value), .steps_done(steps_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predicted cpu state
  logic [31:0] regs [256];
  logic [7:0]  prog [PROG_SIZE];
  logic [7:0]  dmem [DATA_SIZE];
  bit          prog_wr [PROG_SIZE];
  bit          dmem_wr [DATA_SIZE];
  int          pc;
  bit          fz, fn, fc, fv;
  int          steps;
  bit          is_halted;
  logic [1:0]  cause;
  logic [7:0]  last_op;
  int          limit;

  cpu_status_t status_q[$];
  int fails = 0;
  int sent = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_seen = 0;
  int hold_cnt = 0;

  dir_row_t dir_rows[] = '{
    '{ACT_READ_REG,  12'd0,    8'h00, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_READ_REG,  12'd255,  8'h00, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_SPARE_6,   12'hFFF,  8'hFF, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_SPARE_7,   12'h000,  8'h00, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'hFFF,  8'hFF, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd0,    OP_MOVE_IMM, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd1,    8'd1,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd2,    8'd0,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd3,    8'hFF, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_STEP,      12'd0,    8'h00, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd4,    OP_SUB_IMM, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd5,    8'd2,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd6,    8'd0,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd7,    8'd1,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_STEP,      12'd0,    8'h00, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd8,    OP_HALT, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd9,    8'd0,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd10,   8'd0,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_PROG, 12'd11,   8'd0,  0, 32'h0, 1'b0, HC_RUN},
    '{ACT_STEP,      12'd0,    8'h00, 1, 32'h0, 1'b1, HC_OP},
    '{ACT_READ_REG,  12'h102,  8'h00, 1, 32'hFFFF_FFFF, 1'b1, HC_OP},
    '{ACT_STEP,      12'd0,    8'h00, 1, 32'h0, 1'b1, HC_OP},
    '{ACT_RESET,     12'd0,    8'h00, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_READ_REG,  12'd1,    8'h00, 1, 32'h0, 1'b0, HC_RUN},
    '{ACT_LOAD_DATA, 12'hFFF,  8'hAB, 0, 32'h0, 1'b0, HC_RUN},
    '{ACT_READ_DATA, 12'hFFF,  8'h00, 1, 32'hAB, 1'b0, HC_RUN},
    '{ACT_READ_REG,  12'hFFF,  8'h00, 1, 32'h0, 1'b0, HC_RUN}
  };

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("small_cpu_instruction_step_tb: FAIL");
      $finish;
    end
  end

  function automatic void core_clear();
    foreach (regs[i]) regs[i] = '0;
    pc = 0;
    {fz, fn, fc, fv} = '0;
    steps = 0;
    is_halted = 0;
    cause = HC_RUN;
    last_op = '0;
  endfunction

  function automatic bit word_addr_ok(logic [31:0] b);
    return !b[31] && b < DATA_SIZE - 3;
  endfunction

  function automatic bit cc_met(logic [3:0] cc);
    case (cc)
      4'h0: return fz;
      4'h1: return !fz;
      4'h2: return fc;
      4'h3: return !fc;
      4'h4: return fn;
      4'h5: return !fn;
      4'h6: return fv;
      4'h7: return !fv;
      4'h8: return fc && !fz;
      4'h9: return !fc || fz;
      4'hA: return fn == fv;
      4'hB: return fn != fv;
      4'hC: return !fz && fn == fv;
      4'hD: return fz || fn != fv;
      default: return 1'b1;
    endcase
  endfunction

  // one instruction of the core
  function automatic void execute_instr();
    logic [7:0] op, dst, s1, s2;
    logic [31:0] a, b, r, ad, ov;
    bit bad;
    int here;
    op = '0; dst = '0; s1 = '0; s2 = '0;
    bad = pc < 0 || pc >= PROG_SIZE - 4;
    here = pc;
    if (!bad) begin
      op = prog[pc]; dst = prog[pc + 1]; s1 = prog[pc + 2]; s2 = prog[pc + 3];
      pc += 4;
    end
    last_op = op;
    steps++;
    if (steps > limit) begin
      is_halted = 1; cause = HC_LIMIT;
      return;
    end
    if (op == OP_HALT) begin
      is_halted = 1; cause = bad ? HC_PC : HC_OP;
      return;
    end
    if (op >= OP_BR_LO && op <= OP_BR_HI) begin
      if (cc_met(op[3:0])) pc = here + 4 * int'($signed(s2));
      return;
    end
    if (op > OP_ALU_MAX) return;
    a = regs[s1];
    b = (op <= OP_REG_MAX) ? regs[s2] : {24'd0, s2};
    case (op[2:0])
      FN_ADD: begin
        r = a + b;
        regs[dst] = r;
        ov = (a ^ r) & (b ^ r);
        fz = r == 0; fn = r[31]; fc = r < a; fv = ov[31];
      end
      FN_SUB: begin
        r = a - b;
        regs[dst] = r;
        ov = (a ^ b) & (a ^ r);
        fz = r == 0; fn = r[31]; fc = a >= b; fv = ov[31];
      end
      FN_MUL: regs[dst] = a * b;
      FN_DIV: begin
        if (b != 0) begin
          if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) regs[dst] = a;
          else regs[dst] = $signed(a) / $signed(b);
        end
      end
      FN_LOAD: begin
        if (word_addr_ok(b))
          regs[dst] = {dmem[b], dmem[b + 1], dmem[b + 2], dmem[b + 3]};
      end
      FN_STORE: begin
        ad = regs[dst];
        if (word_addr_ok(ad)) begin
          for (int i = 0; i < 4; i++) begin
            dmem[ad + i] = b[31 - 8 * i -: 8];
            dmem_wr[ad + i] = 1;
          end
        end
      end
      FN_MOVE: regs[dst] = b;
      default: ;
    endcase
  endfunction

  // apply one item, return the status it reports
  function automatic cpu_status_t cpu_apply(logic [2:0] act, logic [11:0] addr,
                                            logic [7:0] val);
    cpu_status_t s;
    logic [31:0] rd;
    rd = '0;
    case (act)
      ACT_LOAD_PROG: begin
        if (addr < PROG_SIZE) begin
          prog[addr] = val; prog_wr[addr] = 1;
        end
      end
      ACT_LOAD_DATA: begin
        dmem[addr] = val; dmem_wr[addr] = 1;
      end
      ACT_RESET: core_clear();
      ACT_STEP: if (!is_halted) execute_instr();
      ACT_READ_DATA: rd = {24'd0, dmem[addr]};
      ACT_READ_REG: rd = regs[addr[7:0]];
      default: ;
    endcase
    s.pc = pc[11:0];
    s.halted = is_halted;
    s.cause = cause;
    s.op = last_op;
    {s.z, s.n, s.c, s.v} = {fz, fn, fc, fv};
    s.rv = rd;
    s.steps = steps[16:0];
    return s;
  endfunction

  function automatic logic [7:0] pick_reg();
    return ($urandom_range(4) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
  endfunction

  // random instruction, mostly well formed with a small register set
  function automatic logic [31:0] rand_instr();
    int p;
    logic [7:0] op, d, s1, s2;
    p = $urandom_range(99);
    d = pick_reg(); s1 = pick_reg(); s2 = pick_reg();
    if (p < 3) op = OP_HALT;
    else if (p < 48) begin
      op = 8'($urandom_range(1, 15));
      if (op > OP_REG_MAX && $urandom_range(1) == 1) s2 = 8'($urandom);
    end else if (p < 68) begin
      op = OP_BR_LO + 8'($urandom_range(0, 14));
      s2 = 8'(int'($urandom_range(0, 10)) - 6);
      if ($urandom_range(9) == 0) s2 = 8'($urandom);
    end else if (p < 80) begin
      op = OP_MOVE_IMM;
      s2 = 8'($urandom);
    end else if (p < 90)
      op = ($urandom_range(1) == 1) ? OP_NOP_IMM : 8'($urandom_range(8'h1F, 8'hFF));
    else begin
      op = 8'($urandom); d = 8'($urandom); s1 = 8'($urandom); s2 = 8'($urandom);
    end
    return {op, d, s1, s2};
  endfunction

  // offer one item and wait until it is taken
  task automatic send(logic [2:0] act, logic [11:0] addr, logic [7:0] val);
    if (!quiet && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    address <= addr;
    byte_value <= val;
    status_q.push_back(cpu_apply(act, addr, val));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic put_instr(int base, logic [31:0] ins);
    for (int i = 0; i < 4; i++) send(ACT_LOAD_PROG, 12'(base + i), ins[31 - 8 * i -: 8]);
  endtask

  // step, first filling any program or data byte the step would read
  task automatic step_safely();
    logic [7:0] op, s2;
    logic [31:0] b;
    if (!is_halted && pc >= 0 && pc < PROG_SIZE - 4) begin
      for (int i = 0; i < 4; i++)
        if (!prog_wr[pc + i]) send(ACT_LOAD_PROG, 12'(pc + i), 8'($urandom));
      op = prog[pc];
      s2 = prog[pc + 3];
      if (op != OP_HALT && op <= OP_ALU_MAX && op[2:0] == FN_LOAD) begin
        b = (op <= OP_REG_MAX) ? regs[s2] : {24'd0, s2};
        if (word_addr_ok(b))
          for (int i = 0; i < 4; i++)
            if (!dmem_wr[b + i]) send(ACT_LOAD_DATA, 12'(b + i), 8'($urandom));
      end
    end
    send(ACT_STEP, 12'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit = int'(v);
  endtask

  task automatic random_phase(int n);
    int start, p, a;
    logic [31:0] ins;
    start = sent;
    while (sent - start < n) begin
      p = $urandom_range(99);
      if (p < 26) begin
        ins = rand_instr();
        a = ($urandom_range(9) == 0) ? 4 * $urandom_range(0, 63) : 4 * $urandom_range(0, 15);
        put_instr(a, ins);
      end else if (p < 30) send(ACT_LOAD_PROG, 12'($urandom), 8'($urandom));
      else if (p < 64) step_safely();
      else if (p < 70) send(ACT_RESET, 12'($urandom), 8'($urandom));
      else if (p < 78) begin
        a = ($urandom_range(1) == 1) ? $urandom_range(0, 63) : $urandom_range(0, 4095);
        if (!dmem_wr[a]) send(ACT_LOAD_DATA, 12'(a), 8'($urandom));
        send(ACT_READ_DATA, 12'(a), 8'($urandom));
      end else if (p < 86) send(ACT_READ_REG, 12'($urandom), 8'($urandom));
      else if (p < 94) send(ACT_LOAD_DATA, 12'($urandom), 8'($urandom));
      else if (p < 97) send(3'($urandom_range(6, 7)), 12'($urandom), 8'($urandom));
      else repeat (4) step_safely();
    end
  endtask

  task automatic chk(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    cpu_status_t e;
    if (!rst && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        e = status_q.pop_front();
        chk("program_counter", {20'd0, e.pc}, {20'd0, program_counter});
        chk("halted", e.halted, halted);
        chk("halt_cause", e.cause, halt_cause);
        chk("last_opcode", e.op, last_opcode);
        chk("flag_zero", e.z, flag_zero);
        chk("flag_negative", e.n, flag_negative);
        chk("flag_carry", e.c, flag_carry);
        chk("flag_overflow", e.v, flag_overflow);
        chk("read_value", e.rv, read_value);
        chk("steps_done", e.steps, steps_done);
      end
    end
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_cnt = HOLD_CYCLES;
    end
    if (rst) out_stall <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else out_stall <= !quiet && ($urandom_range(99) < 31);
  end

  // stimulus
  initial begin
    foreach (prog_wr[i]) prog_wr[i] = 0;
    foreach (dmem_wr[i]) dmem_wr[i] = 0;
    core_clear();
    limit = int'(LIMIT_RESET);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items
    foreach (dir_rows[i]) begin
      send(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].val);
      if (dir_rows[i].typed) begin
        status_q[status_q.size() - 1].rv = dir_rows[i].rv;
        status_q[status_q.size() - 1].halted = dir_rows[i].halt;
        status_q[status_q.size() - 1].cause = dir_rows[i].cause;
      end
    end

    // build INT_MIN, divide it by -1 and by zero, overflow add, word store and load
    put_instr(0,  {OP_MOVE_IMM, 8'd5, 8'd0, 8'h80});
    put_instr(4,  {OP_MUL_REG, 8'd5, 8'd5, 8'd5});
    put_instr(8,  {OP_MUL_REG, 8'd5, 8'd5, 8'd5});
    put_instr(12, {OP_MUL_IMM, 8'd5, 8'd5, 8'd8});
    put_instr(16, {OP_SUB_IMM, 8'd6, 8'd0, 8'd1});
    put_instr(20, {OP_DIV_REG, 8'd7, 8'd5, 8'd6});
    put_instr(24, {OP_DIV_REG, 8'd8, 8'd5, 8'd0});
    put_instr(28, {OP_ADD_REG, 8'd9, 8'd5, 8'd5});
    put_instr(32, {OP_MOVE_IMM, 8'd10, 8'd0, 8'h10});
    put_instr(36, {OP_STORE_RG, 8'd10, 8'd0, 8'd5});
    put_instr(40, {OP_LOAD_IMM, 8'd11, 8'd0, 8'h10});
    put_instr(44, {OP_HALT, 8'd0, 8'd0, 8'd0});
    send(ACT_RESET, 12'd0, 8'd0);
    repeat (13) step_safely();
    send(ACT_READ_REG, 12'd7, 8'd0);
    send(ACT_READ_REG, 12'd11, 8'd0);

    // widest limit, with a long receiver hold and a mid-phase drain
    write_limit(16'hFFFF);
    hold_go <= ~hold_go;
    random_phase(PHASE_ITEMS / 2);
    drain();
    random_phase(PHASE_ITEMS / 2);

    write_limit(16'd1);
    random_phase(PHASE_ITEMS);

    write_limit(16'd7);
    random_phase(PHASE_ITEMS);

    // no idling on either side
    write_limit(16'd40);
    quiet = 1;
    random_phase(PHASE_ITEMS);
    quiet = 0;

    write_limit(LIMIT_RESET);
    random_phase(PHASE_ITEMS);

    write_limit(16'd300);
    random_phase(PHASE_ITEMS);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fails == 0) $display("small_cpu_instruction_step_tb: PASS");
    else $display("small_cpu_instruction_step_tb: FAIL");
    $finish;
  end

endmodule
